>>> src/detection_head_decode_core_assert.svh
// ---------------------------------------------------------------------------
// Detection head decode assertion macros
// Shared assertion forms, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DETECTION_HEAD_DECODE_CORE_ASSERT_SVH
`define DETECTION_HEAD_DECODE_CORE_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define DHD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define DHD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define DHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dhd_pkg.sv
// ---------------------------------------------------------------------------
// Detection head decode package
// Widths, register indices, reset values and the pipeline tag type.
// ---------------------------------------------------------------------------
package dhd_pkg;

    localparam int VAL_W   = 8;
    localparam int SCALE_W = 24;
    localparam int THR_W   = 32;
    localparam int CC_W    = 9;
    localparam int V_W     = 33;
    localparam int EDGE_W  = 34;
    localparam int CLASS_W = 8;
    localparam int CONF_W  = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MAX_CLASSES = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_OFFSET    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEQUANT_SCALE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT     = 8'd3;

    localparam logic [VAL_W-1:0]   RST_QUANT_OFFSET    = 8'd0;
    localparam logic [SCALE_W-1:0] RST_DEQUANT_SCALE   = 24'd4096;
    localparam logic [THR_W-1:0]   RST_SCORE_THRESHOLD = 32'd524288;
    localparam logic [CC_W-1:0]    RST_CLASS_COUNT     = 9'd80;

    typedef struct packed {
        logic               is_box;
        logic [1:0]         box_idx;
        logic [CLASS_W-1:0] class_idx;
        logic               is_last;
    } dhd_tag_t;

endpackage

>>> src/dhd_sequencer.sv
// ---------------------------------------------------------------------------
// Detection head decode sequencer
// Input register and per-anchor position tracking for box values and scores.
// ---------------------------------------------------------------------------
module dhd_sequencer #(
    parameter int MAX_CLASSES = dhd_pkg::DEF_MAX_CLASSES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [dhd_pkg::VAL_W-1:0]    value,
    output logic                         in_stall,
    input  logic [dhd_pkg::CC_W-1:0]     class_count,
    input  logic                         b_ready,
    output logic                         a_valid,
    output logic [dhd_pkg::VAL_W-1:0]    a_value,
    output dhd_pkg::dhd_tag_t            a_tag
);
    import dhd_pkg::*;

    localparam int NW = $clog2(MAX_CLASSES + 1);

    logic               a_valid_reg;
    logic [VAL_W-1:0]   a_value_reg;
    dhd_tag_t           a_tag_reg;
    logic               box_phase_reg;
    logic [1:0]         box_idx_reg;
    logic [NW-1:0]      cls_reg;

    logic               a_ready;
    logic               accept;
    logic [NW-1:0]      n_eff;
    logic [NW:0]        c_plus;
    logic               last_score;

    always_comb
    begin
        if (class_count == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(class_count) > 32'(MAX_CLASSES))
        begin
            n_eff = NW'(MAX_CLASSES);
        end
        else
        begin
            n_eff = NW'(class_count);
        end
    end

    assign c_plus     = {1'b0, cls_reg} + (NW + 1)'(1);
    assign last_score = c_plus >= {1'b0, n_eff};

    assign a_ready  = !a_valid_reg || b_ready;
    assign accept   = in_valid && a_ready;
    assign in_stall = !a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            box_phase_reg <= 1'b1;
            box_idx_reg   <= 2'd0;
            cls_reg       <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (accept)
            begin
                if (box_phase_reg)
                begin
                    box_idx_reg <= box_idx_reg + 2'd1;
                    if (box_idx_reg == 2'd3)
                    begin
                        box_phase_reg <= 1'b0;
                    end
                end
                else if (last_score)
                begin
                    box_phase_reg <= 1'b1;
                    cls_reg       <= '0;
                end
                else
                begin
                    cls_reg <= cls_reg + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_value_reg         <= value;
            a_tag_reg.is_box    <= box_phase_reg;
            a_tag_reg.box_idx   <= box_idx_reg;
            a_tag_reg.class_idx <= CLASS_W'(cls_reg);
            a_tag_reg.is_last   <= !box_phase_reg && last_score;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_value = a_value_reg;
    assign a_tag   = a_tag_reg;

endmodule

>>> src/dhd_dequant.sv
// ---------------------------------------------------------------------------
// Detection head decode dequantiser
// Minus the zero point, times the Q20 scale; one value a cycle unless stalled.
// ---------------------------------------------------------------------------
module dhd_dequant (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          a_valid,
    input  logic [dhd_pkg::VAL_W-1:0]     a_value,
    input  dhd_pkg::dhd_tag_t             a_tag,
    input  logic [dhd_pkg::VAL_W-1:0]     quant_offset,
    input  logic [dhd_pkg::SCALE_W-1:0]   dequant_scale,
    input  logic                          b_ready,
    output logic                          b_valid,
    output logic signed [dhd_pkg::V_W-1:0] b_v,
    output dhd_pkg::dhd_tag_t             b_tag
);
    import dhd_pkg::*;

    localparam int P_W = VAL_W + SCALE_W + 2;

    logic                    b_valid_reg;
    logic signed [V_W-1:0]   b_v_reg;
    dhd_tag_t                b_tag_reg;

    logic signed [VAL_W:0]   diff;
    logic signed [SCALE_W:0] scale_s;
    logic signed [P_W-1:0]   prod;

    assign diff    = $signed({a_value[VAL_W-1], a_value})
                   - $signed({quant_offset[VAL_W-1], quant_offset});
    assign scale_s = $signed({1'b0, dequant_scale});
    assign prod    = P_W'(diff) * P_W'(scale_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid && b_ready)
        begin
            b_v_reg   <= prod[V_W-1:0];
            b_tag_reg <= a_tag;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_v     = b_v_reg;
    assign b_tag   = b_tag_reg;

endmodule

>>> src/dhd_accum.sv
// ---------------------------------------------------------------------------
// Detection head decode accumulator
// Holds the box values and running argmax, and forms the corner box result.
// ---------------------------------------------------------------------------
module dhd_accum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               b_valid,
    input  logic signed [dhd_pkg::V_W-1:0]     b_v,
    input  dhd_pkg::dhd_tag_t                  b_tag,
    input  logic [dhd_pkg::THR_W-1:0]          score_threshold,
    output logic                               b_ready,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [dhd_pkg::EDGE_W-1:0]  x_min,
    output logic signed [dhd_pkg::EDGE_W-1:0]  y_min,
    output logic signed [dhd_pkg::EDGE_W-1:0]  x_max,
    output logic signed [dhd_pkg::EDGE_W-1:0]  y_max,
    output logic [dhd_pkg::CLASS_W-1:0]        class_index,
    output logic [dhd_pkg::CONF_W-1:0]         confidence
);
    import dhd_pkg::*;

    `include "detection_head_decode_core_assert.svh"

    logic signed [V_W-1:0]    box_reg [4];
    logic signed [V_W-1:0]    best_reg;
    logic [CLASS_W-1:0]       best_class_reg;
    logic                     out_valid_reg;
    logic signed [EDGE_W-1:0] x_min_reg;
    logic signed [EDGE_W-1:0] y_min_reg;
    logic signed [EDGE_W-1:0] x_max_reg;
    logic signed [EDGE_W-1:0] y_max_reg;
    logic [CLASS_W-1:0]       class_reg;
    logic [CONF_W-1:0]        conf_reg;

    logic                     out_free;
    logic                     go;
    logic                     upd;
    logic signed [V_W-1:0]    best_next;
    logic [CLASS_W-1:0]       best_class_next;
    logic                     emit;
    logic signed [EDGE_W-1:0] cx;
    logic signed [EDGE_W-1:0] cy;
    logic signed [EDGE_W-1:0] hw;
    logic signed [EDGE_W-1:0] hh;

    assign out_free = !out_valid_reg || !out_stall;
    assign b_ready  = !b_valid || !b_tag.is_last || out_free;
    assign go       = b_valid && b_ready;

    assign upd             = b_v > best_reg;
    assign best_next       = upd ? b_v : best_reg;
    assign best_class_next = upd ? b_tag.class_idx : best_class_reg;
    assign emit            = $unsigned(best_next) >= {1'b0, score_threshold};

    // The half extent is an arithmetic shift, which rounds towards minus infinity.
    assign cx = $signed({box_reg[0][V_W-1], box_reg[0]});
    assign cy = $signed({box_reg[1][V_W-1], box_reg[1]});
    assign hw = $signed({{2{box_reg[2][V_W-1]}}, box_reg[2][V_W-1:1]});
    assign hh = $signed({{2{box_reg[3][V_W-1]}}, box_reg[3][V_W-1:1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg       <= '0;
            best_class_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (go && !b_tag.is_box)
            begin
                if (b_tag.is_last)
                begin
                    best_reg       <= '0;
                    best_class_reg <= '0;
                end
                else
                begin
                    best_reg       <= best_next;
                    best_class_reg <= best_class_next;
                end
            end
            if (go && b_tag.is_last && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && b_tag.is_box)
        begin
            box_reg[b_tag.box_idx] <= b_v;
        end
        if (go && b_tag.is_last && emit)
        begin
            x_min_reg <= cx - hw;
            y_min_reg <= cy - hh;
            x_max_reg <= cx + hw;
            y_max_reg <= cy + hh;
            class_reg <= best_class_next;
            conf_reg  <= best_next[CONF_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_min       = x_min_reg;
    assign y_min       = y_min_reg;
    assign x_max       = x_max_reg;
    assign y_max       = y_max_reg;
    assign class_index = class_reg;
    assign confidence  = conf_reg;

    `DHD_ASSERT(a_best_nonneg, !best_reg[V_W-1], "best score went negative")
    `DHD_ASSERT_IMPL(a_conf_threshold, out_valid_reg, conf_reg >= score_threshold,
        "result below threshold offered")
    `DHD_ASSERT_IMPL(a_block_cause, b_valid && !b_ready, out_valid_reg && out_stall,
        "pipeline blocked without a waiting result")
    `DHD_ASSERT_NEXT(a_block_hold, b_valid && !b_ready,
        $stable(best_reg) && $stable(best_class_reg), "argmax changed while blocked")

endmodule

>>> src/detection_head_decode_core.sv
// ---------------------------------------------------------------------------
// Detection head decode core
// Dequantises a per-anchor int8 stream and emits corner boxes with argmax class.
// ---------------------------------------------------------------------------
// Accepts one value per cycle; the dequantiser multiply is a stage of its own.
// An anchor's last score passes the input, multiply and result registers in turn.
// Only a waiting result that is stalled on an anchor's last score holds the input.
// Reset clears the pipeline, the anchor position and the argmax, and loads
// the register defaults; results and box values hold no reset.
module detection_head_decode_core #(
    parameter int MAX_CLASSES = dhd_pkg::DEF_MAX_CLASSES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dhd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dhd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dhd_pkg::VAL_W-1:0]           value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dhd_pkg::EDGE_W-1:0]   x_min,
    output logic signed [dhd_pkg::EDGE_W-1:0]   y_min,
    output logic signed [dhd_pkg::EDGE_W-1:0]   x_max,
    output logic signed [dhd_pkg::EDGE_W-1:0]   y_max,
    output logic [dhd_pkg::CLASS_W-1:0]         class_index,
    output logic [dhd_pkg::CONF_W-1:0]          confidence
);
    import dhd_pkg::*;

    logic [VAL_W-1:0]   offset_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [CC_W-1:0]    class_count_reg;

    logic               a_valid;
    logic [VAL_W-1:0]   a_value;
    dhd_tag_t           a_tag;
    logic               b_ready;
    logic               b_valid;
    logic signed [V_W-1:0] b_v;
    dhd_tag_t           b_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= RST_QUANT_OFFSET;
            scale_reg       <= RST_DEQUANT_SCALE;
            threshold_reg   <= RST_SCORE_THRESHOLD;
            class_count_reg <= RST_CLASS_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUANT_OFFSET:    offset_reg      <= cfg_data[VAL_W-1:0];
                CFG_DEQUANT_SCALE:   scale_reg       <= cfg_data[SCALE_W-1:0];
                CFG_SCORE_THRESHOLD: threshold_reg   <= cfg_data[THR_W-1:0];
                CFG_CLASS_COUNT:     class_count_reg <= cfg_data[CC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dhd_sequencer #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .value       (value),
        .in_stall    (in_stall),
        .class_count (class_count_reg),
        .b_ready     (b_ready),
        .a_valid     (a_valid),
        .a_value     (a_value),
        .a_tag       (a_tag)
    );

    dhd_dequant u_dequant (
        .clk           (clk),
        .rst_n         (rst_n),
        .a_valid       (a_valid),
        .a_value       (a_value),
        .a_tag         (a_tag),
        .quant_offset  (offset_reg),
        .dequant_scale (scale_reg),
        .b_ready       (b_ready),
        .b_valid       (b_valid),
        .b_v           (b_v),
        .b_tag         (b_tag)
    );

    dhd_accum u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .b_valid         (b_valid),
        .b_v             (b_v),
        .b_tag           (b_tag),
        .score_threshold (threshold_reg),
        .b_ready         (b_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_min           (x_min),
        .y_min           (y_min),
        .x_max           (x_max),
        .y_max           (y_max),
        .class_index     (class_index),
        .confidence      (confidence)
    );

endmodule

>>> verif/tb_detection_head_decode_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Detection head decode core testbench
// Streams int8 anchor values into the core, predicts each corner-box detection
// bit for bit from its own copy of the dequantiser, box store and argmax, and
// compares every output transfer with the oldest predicted detection. A short
// table of directed values comes first, followed by random phases under
// changing register settings, random idling and long output hold-offs.
// ---------------------------------------------------------------------------
module tb_detection_head_decode_core;
    import dhd_pkg::*;

    localparam int CLASS_LIMIT   = DEF_MAX_CLASSES;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_LIMIT    = 2000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x_min;
        logic signed [EDGE_W-1:0] y_min;
        logic signed [EDGE_W-1:0] x_max;
        logic signed [EDGE_W-1:0] y_max;
        logic [CLASS_W-1:0]       class_index;
        logic [CONF_W-1:0]        confidence;
    } detection_t;

    typedef enum logic {ROW_CFG, ROW_VALUE} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} row_check_t;

    typedef struct {
        row_kind_t             kind;
        row_check_t            check;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [VAL_W-1:0]      raw;
        detection_t            result;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [VAL_W-1:0]         value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [EDGE_W-1:0] x_min;
    logic signed [EDGE_W-1:0] y_min;
    logic signed [EDGE_W-1:0] x_max;
    logic signed [EDGE_W-1:0] y_max;
    logic [CLASS_W-1:0]       class_index;
    logic [CONF_W-1:0]        confidence;

    logic signed [VAL_W-1:0]  zero_pt;
    logic [SCALE_W-1:0]       scale_q20;
    logic [THR_W-1:0]         thresh_q20;
    logic [CC_W-1:0]          class_cnt;
    int                       anchor_pos;
    logic signed [V_W-1:0]    box_q20 [4];
    logic signed [V_W-1:0]    best_q20;
    logic [CLASS_W-1:0]       best_cls;

    detection_t expected_boxes [$];
    stim_row_t  directed_plan [$];

    int mismatches;
    int results_seen;
    int value_transfers;
    int random_items;
    int phase;
    int holds_done;
    int idle_cycles;
    bit steady;
    bit hold_req;

    detection_t got_box;
    detection_t want_box;

    detection_head_decode_core uut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void clear_anchor();
        anchor_pos = 0;
        foreach (box_q20[i]) box_q20[i] = '0;
        best_q20 = '0;
        best_cls = '0;
    endfunction

    function automatic void decode_value(input logic [VAL_W-1:0] raw, output bit emit,
                                         output detection_t det);
        longint                   prod;
        logic signed [V_W-1:0]    v;
        logic signed [EDGE_W-1:0] half_w;
        logic signed [EDGE_W-1:0] half_h;
        int                       n;
        int                       c;
        emit = 1'b0;
        det  = '0;
        prod = (longint'($signed(raw)) - longint'(zero_pt)) * longint'(scale_q20);
        v    = prod[V_W-1:0];
        n    = class_cnt;
        if (n == 0)
            n = 1;
        if (n > CLASS_LIMIT)
            n = CLASS_LIMIT;
        if (anchor_pos < 4)
        begin
            box_q20[anchor_pos] = v;
            anchor_pos++;
            return;
        end
        c = anchor_pos - 4;
        if (v > best_q20)
        begin
            best_q20 = v;
            best_cls = c[CLASS_W-1:0];
        end
        if (c + 1 < n)
        begin
            anchor_pos++;
            return;
        end
        if ($unsigned(best_q20) >= {1'b0, thresh_q20})
        begin
            emit            = 1'b1;
            half_w          = EDGE_W'(box_q20[2] >>> 1);
            half_h          = EDGE_W'(box_q20[3] >>> 1);
            det.x_min       = EDGE_W'(box_q20[0]) - half_w;
            det.y_min       = EDGE_W'(box_q20[1]) - half_h;
            det.x_max       = EDGE_W'(box_q20[0]) + half_w;
            det.y_max       = EDGE_W'(box_q20[1]) + half_h;
            det.class_index = best_cls;
            det.confidence  = best_q20[CONF_W-1:0];
        end
        clear_anchor();
    endfunction

    function automatic logic [VAL_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 8'h7F;
            1:       return 8'h80;
            2:       return zero_pt;
            3:       return zero_pt + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r.kind   = ROW_CFG;
        r.check  = CHK_NONE;
        r.idx    = idx;
        r.data   = data;
        r.raw    = '0;
        r.result = '0;
        directed_plan = {directed_plan, r};
    endfunction

    function automatic void add_raw(input logic [VAL_W-1:0] raw, input row_check_t check);
        stim_row_t r;
        r.kind   = ROW_VALUE;
        r.check  = check;
        r.idx    = '0;
        r.data   = '0;
        r.raw    = raw;
        r.result = '0;
        directed_plan = {directed_plan, r};
    endfunction

    function automatic void add_detection(input logic [VAL_W-1:0] raw,
                                          input logic signed [EDGE_W-1:0] x0, y0, x1, y1,
                                          input logic [CLASS_W-1:0] cls,
                                          input logic [CONF_W-1:0] conf);
        stim_row_t r;
        r.kind   = ROW_VALUE;
        r.check  = CHK_RESULT;
        r.idx    = '0;
        r.data   = '0;
        r.raw    = raw;
        r.result = '{x0, y0, x1, y1, cls, conf};
        directed_plan = {directed_plan, r};
    endfunction

    task automatic send_value(input logic [VAL_W-1:0] raw, input row_check_t check,
                              input detection_t typed);
        detection_t det;
        bit         emit;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= raw;
        do @(posedge clk); while (in_stall);
        value_transfers++;
        decode_value(raw, emit, det);
        if (check == CHK_MODEL && emit)
            expected_boxes = {expected_boxes, det};
        else if (check == CHK_RESULT)
            expected_boxes = {expected_boxes, typed};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_QUANT_OFFSET:    zero_pt    = data[VAL_W-1:0];
            CFG_DEQUANT_SCALE:   scale_q20  = data[SCALE_W-1:0];
            CFG_SCORE_THRESHOLD: thresh_q20 = data[THR_W-1:0];
            CFG_CLASS_COUNT:     class_cnt  = data[CC_W-1:0];
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
                out_stall <= !steady && ($urandom_range(0, 99) < 33);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            got_box = '{x_min, y_min, x_max, y_max, class_index, confidence};
            if (expected_boxes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected detection: box (%0d, %0d, %0d, %0d) class %0d conf %0d",
                             got_box.x_min, got_box.y_min, got_box.x_max, got_box.y_max,
                             got_box.class_index, got_box.confidence);
            end
            else
            begin
                want_box = expected_boxes.pop_front();
                if (got_box.x_min !== want_box.x_min || got_box.y_min !== want_box.y_min ||
                    got_box.x_max !== want_box.x_max || got_box.y_max !== want_box.y_max ||
                    got_box.class_index !== want_box.class_index ||
                    got_box.confidence !== want_box.confidence)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("result %0d expected (%0d, %0d, %0d, %0d) class %0d conf %0d",
                                 results_seen, want_box.x_min, want_box.y_min, want_box.x_max,
                                 want_box.y_max, want_box.class_index, want_box.confidence);
                        $display("result %0d got      (%0d, %0d, %0d, %0d) class %0d conf %0d",
                                 results_seen, got_box.x_min, got_box.y_min, got_box.x_max,
                                 got_box.y_max, got_box.class_index, got_box.confidence);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("tb_detection_head_decode_core failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] data;
        int                    anchors;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        value      = '0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        zero_pt    = RST_QUANT_OFFSET;
        scale_q20  = RST_DEQUANT_SCALE;
        thresh_q20 = RST_SCORE_THRESHOLD;
        class_cnt  = RST_CLASS_COUNT;
        clear_anchor();

        // Reset defaults: a score just under the half-unit threshold gives nothing.
        add_cfg(CFG_CLASS_COUNT, 32'd1);
        add_raw(8'h7F, CHK_MODEL);
        add_raw(8'h80, CHK_MODEL);
        add_raw(8'h7F, CHK_MODEL);
        add_raw(8'h80, CHK_MODEL);
        add_raw(8'h7F, CHK_NONE);
        // Largest scale with the lowest zero point; the score never beats zero.
        add_cfg(CFG_SCORE_THRESHOLD, 32'd0);
        add_cfg(CFG_DEQUANT_SCALE, 32'h00FF_FFFF);
        add_cfg(CFG_QUANT_OFFSET, 32'hFFFF_FF80);
        add_raw(8'h7F, CHK_MODEL);
        add_raw(8'h80, CHK_MODEL);
        add_raw(8'h7F, CHK_MODEL);
        add_raw(8'h80, CHK_MODEL);
        add_detection(8'h80, 34'sd2139094913, 34'sd0, 34'sd6417284737, 34'sd0, 8'd0, 32'd0);
        // Highest zero point, unit scale, class count of zero, odd negative width.
        add_cfg(CFG_QUANT_OFFSET, 32'h0000_007F);
        add_cfg(CFG_DEQUANT_SCALE, 32'd1);
        add_cfg(CFG_CLASS_COUNT, 32'd0);
        add_raw(8'h80, CHK_MODEL);
        add_raw(8'h7F, CHK_MODEL);
        add_raw(8'h80, CHK_MODEL);
        add_raw(8'h7F, CHK_MODEL);
        add_detection(8'h7F, -34'sd127, 34'sd0, -34'sd383, 34'sd0, 8'd0, 32'd0);
        // Tie on the best score keeps the first class; count lowered mid-anchor.
        add_cfg(CFG_QUANT_OFFSET, 32'd0);
        add_cfg(CFG_DEQUANT_SCALE, 32'd4096);
        add_cfg(CFG_CLASS_COUNT, 32'd4);
        add_raw(8'd10, CHK_MODEL);
        add_raw(8'd20, CHK_MODEL);
        add_raw(8'd30, CHK_MODEL);
        add_raw(8'd40, CHK_MODEL);
        add_raw(8'd5, CHK_MODEL);
        add_raw(8'd9, CHK_MODEL);
        add_cfg(CFG_CLASS_COUNT, 32'd1);
        add_detection(8'd9, -34'sd20480, 34'sd0, 34'sd102400, 34'sd163840, 8'd1, 32'd36864);
        // Best possible score equal to the threshold is still given.
        add_cfg(CFG_QUANT_OFFSET, 32'h0000_0080);
        add_cfg(CFG_DEQUANT_SCALE, 32'h00FF_FFFF);
        add_cfg(CFG_SCORE_THRESHOLD, 32'd4278189825);
        add_raw(8'd0, CHK_MODEL);
        add_raw(8'd0, CHK_MODEL);
        add_raw(8'd0, CHK_MODEL);
        add_raw(8'd0, CHK_MODEL);
        add_raw(8'h7F, CHK_MODEL);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed_plan[i].idx, directed_plan[i].data);
            end
            else
                send_value(directed_plan[i].raw, directed_plan[i].check,
                           directed_plan[i].result);
        end

        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            settle();
            steady = (phase % 6 == 3);
            if ($urandom_range(0, 9) < 7)
            begin
                data = $urandom();
                case ($urandom_range(0, 4))
                    0: data[VAL_W-1:0] = 8'h80;
                    1: data[VAL_W-1:0] = 8'h7F;
                    default: ;
                endcase
                write_reg(CFG_QUANT_OFFSET, data);
            end
            if ($urandom_range(0, 9) < 7)
            begin
                data = $urandom();
                case ($urandom_range(0, 5))
                    0: data[SCALE_W-1:0] = '0;
                    1: data[SCALE_W-1:0] = '1;
                    2: data[SCALE_W-1:0] = 24'($urandom_range(1, 4096));
                    default: ;
                endcase
                write_reg(CFG_DEQUANT_SCALE, data);
            end
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = $urandom();
                    default: data = $urandom_range(0, 32'(scale_q20) * 100);
                endcase
                write_reg(CFG_SCORE_THRESHOLD, data);
            end
            data = $urandom();
            if (phase == 5)
                data[CC_W-1:0] = 9'(CLASS_LIMIT);
            else if (phase == 11)
                data[CC_W-1:0] = 9'($urandom_range(CLASS_LIMIT + 1, 511));
            else
                case ($urandom_range(0, 9))
                    0:       data[CC_W-1:0] = '0;
                    1:       data[CC_W-1:0] = 9'($urandom_range(9, 24));
                    default: data[CC_W-1:0] = 9'($urandom_range(1, 8));
                endcase
            write_reg(CFG_CLASS_COUNT, data);
            if ($urandom_range(0, 9) == 0)
                write_reg(8'($urandom_range(4, 255)), $urandom());
            anchors = (phase == 5 || phase == 11) ? 1 : $urandom_range(2, 16);
            if (phase % 8 == 2)
            begin
                write_reg(CFG_SCORE_THRESHOLD, 32'd0);
                write_reg(CFG_CLASS_COUNT, 32'd1);
                steady   = 1'b1;
                hold_req = 1'b1;
                anchors  = 30;
            end
            repeat (anchors)
            begin
                do
                begin
                    send_value(pick_raw(), CHK_MODEL, '0);
                    random_items++;
                end
                while (anchor_pos != 0);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6))
                begin
                    send_value(pick_raw(), CHK_MODEL, '0);
                    random_items++;
                end
        end

        settle();
        $display("Run covered %0d value transfers and %0d detections over %0d random phases.",
                 value_transfers, results_seen, phase);
        $display("It took in register extremes, odd class counts and %0d long output hold-offs.",
                 holds_done);
        if (mismatches == 0 && expected_boxes.size() == 0)
            $display("tb_detection_head_decode_core passed");
        else
            $display("tb_detection_head_decode_core failed");
        $finish;
    end

endmodule
